// ===== rtl/midi_running_status_parser_unit_defines.svh =====
// Assertion macros shared by the MIDI running-status parser modules.
`ifndef MIDI_RUNNING_STATUS_PARSER_UNIT_DEFINES_SVH
`define MIDI_RUNNING_STATUS_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define MRSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrsp assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define MRSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrsp assertion failed");

`endif

// ===== rtl/mrsp_pkg.sv =====
// Types and constants shared by the MIDI running-status parser modules.
package mrsp_pkg;

  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 7;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 14;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY     = 4'hA;
  localparam logic [3:0] NIB_CC       = 4'hB;
  localparam logic [3:0] NIB_CHPR     = 4'hD;
  localparam logic [3:0] NIB_BEND     = 4'hE;
  localparam logic [7:0] SYSEX_START  = 8'hF0;

  localparam logic DIALECT_RESET = 1'b1;

  typedef enum logic [2:0] {
    KIND_NOTE   = 3'd0,
    KIND_POLY   = 3'd1,
    KIND_CC     = 3'd2,
    KIND_CHPR   = 3'd3,
    KIND_BEND   = 3'd4,
    KIND_SYSEX  = 3'd5,
    KIND_REJECT = 3'd6
  } kind_t;

  typedef struct packed {
    logic              first;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAN_W-1:0]  channel;
    logic [DATA_W-1:0]  number;
    logic [VALUE_W-1:0] value;
    logic [BYTE_W-1:0]  rejected;
    logic               from_note_off;
  } result_t;

endpackage

// ===== rtl/mrsp_in_stage.sv =====
// Input register of the parser: holds one accepted byte until the core takes it.
module mrsp_in_stage
  import mrsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [BYTE_W-1:0] s_data,
  input  logic              s_first,
  input  logic              advance,
  output logic              valid,
  output item_t             item
);

  logic valid_next;

  assign s_ready = !valid || advance;

  always_comb begin
    if (s_valid && s_ready) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item.first <= s_first;
      item.data  <= s_data;
    end
  end

endmodule

// ===== rtl/mrsp_core.sv =====
// Running-status state, dialect register and the per-byte decode.
module mrsp_core
  import mrsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_write,
  input  logic    cfg_value,
  input  logic    advance,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

`include "midi_running_status_parser_unit_defines.svh"

  logic              dialect;
  kind_t             running_kind, running_kind_next;
  logic [CHAN_W-1:0] running_channel, running_channel_next;
  logic              running_from_note_off, running_from_note_off_next;
  logic              pair_phase, pair_phase_next;
  logic [DATA_W-1:0] held_first_byte, held_first_byte_next;
  logic              discard_rest, discard_rest_next;

  logic              kind_ok;
  logic              phase_in;
  logic              do_data;
  logic [DATA_W-1:0] b7;
  logic [3:0]        hi;
  kind_t             new_kind;

  always_comb begin
    case (running_kind)
      KIND_NOTE, KIND_CC, KIND_SYSEX: kind_ok = 1'b1;
      KIND_POLY:                      kind_ok = !dialect;
      KIND_CHPR, KIND_BEND:           kind_ok = dialect;
      default:                        kind_ok = 1'b0;
    endcase
  end

  always_comb begin
    hi = item.data[BYTE_W-1 -: 4];
    if (hi == NIB_NOTE_OFF || hi == NIB_NOTE_ON) begin
      new_kind = KIND_NOTE;
    end else if (hi == NIB_POLY && !dialect) begin
      new_kind = KIND_POLY;
    end else if (hi == NIB_CC) begin
      new_kind = KIND_CC;
    end else if (hi == NIB_CHPR && dialect) begin
      new_kind = KIND_CHPR;
    end else if (hi == NIB_BEND && dialect) begin
      new_kind = KIND_BEND;
    end else if (item.data == SYSEX_START) begin
      new_kind = KIND_SYSEX;
    end else begin
      new_kind = KIND_REJECT;
    end
  end

  always_comb begin
    b7 = item.data[DATA_W-1:0];
    running_kind_next          = running_kind;
    running_channel_next       = running_channel;
    running_from_note_off_next = running_from_note_off;
    pair_phase_next            = pair_phase;
    held_first_byte_next       = held_first_byte;
    discard_rest_next          = discard_rest;
    phase_in                   = pair_phase;
    do_data                    = 1'b0;
    res_valid                  = 1'b0;
    res.kind                   = KIND_SYSEX;
    res.channel                = running_channel;
    res.number                 = '0;
    res.value                  = '0;
    res.rejected               = '0;
    res.from_note_off          = 1'b0;

    if (!item.first) begin
      do_data = !discard_rest && (running_kind != KIND_SYSEX);
    end else begin
      // A message start drops any half-built pair and ends a discard.
      phase_in             = 1'b0;
      pair_phase_next      = 1'b0;
      held_first_byte_next = '0;
      discard_rest_next    = 1'b0;
      if (!item.data[BYTE_W-1]) begin
        if (running_kind == KIND_SYSEX) begin
          discard_rest_next = 1'b1;
          res_valid         = 1'b1;
          res.kind          = KIND_SYSEX;
        end else begin
          do_data = 1'b1;
        end
      end else if (new_kind == KIND_REJECT) begin
        discard_rest_next = 1'b1;
        res_valid         = 1'b1;
        res.kind          = KIND_REJECT;
        res.rejected      = item.data;
      end else begin
        running_kind_next          = new_kind;
        running_from_note_off_next = (hi == NIB_NOTE_OFF);
        if (new_kind == KIND_SYSEX) begin
          res_valid = 1'b1;
          res.kind  = KIND_SYSEX;
        end else begin
          running_channel_next = item.data[CHAN_W-1:0];
        end
      end
    end

    if (do_data && kind_ok) begin
      if (running_kind == KIND_CHPR) begin
        res_valid = 1'b1;
        res.kind  = KIND_CHPR;
        res.value = {{(VALUE_W-DATA_W){1'b0}}, b7};
      end else if (!phase_in) begin
        held_first_byte_next = b7;
        pair_phase_next      = 1'b1;
      end else begin
        pair_phase_next = 1'b0;
        res_valid       = 1'b1;
        res.kind        = running_kind;
        if (running_kind == KIND_BEND) begin
          res.value = {b7, held_first_byte};
        end else begin
          res.number        = held_first_byte;
          res.value         = {{(VALUE_W-DATA_W){1'b0}}, b7};
          res.from_note_off = (running_kind == KIND_NOTE) && running_from_note_off;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dialect <= DIALECT_RESET;
    end else if (cfg_write) begin
      dialect <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_kind          <= KIND_NOTE;
      running_channel       <= '0;
      running_from_note_off <= 1'b0;
      pair_phase            <= 1'b0;
      held_first_byte       <= '0;
      discard_rest          <= 1'b0;
    end else if (advance) begin
      running_kind          <= running_kind_next;
      running_channel       <= running_channel_next;
      running_from_note_off <= running_from_note_off_next;
      pair_phase            <= pair_phase_next;
      held_first_byte       <= held_first_byte_next;
      discard_rest          <= discard_rest_next;
    end
  end

  `MRSP_ASSERT_IMPL(a_no_reject_running, 1'b1, running_kind != KIND_REJECT)
  `MRSP_ASSERT_IMPL(a_phase_only_paired, pair_phase,
      running_kind != KIND_CHPR && running_kind != KIND_SYSEX)
  `MRSP_ASSERT_IMPL(a_bend_from_running, res_valid && res.kind == KIND_BEND,
      running_kind == KIND_BEND && phase_in)

endmodule

// ===== rtl/mrsp_out_stage.sv =====
// Output register of the parser: holds one event until the receiver takes it.
module mrsp_out_stage
  import mrsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    space,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  logic m_valid_next;

  assign space = !m_valid || m_ready;

  always_comb begin
    if (load) begin
      m_valid_next = 1'b1;
    end else if (m_ready) begin
      m_valid_next = 1'b0;
    end else begin
      m_valid_next = m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

// ===== rtl/midi_running_status_parser_unit.sv =====
// Top level of the MIDI running-status parser.
//
// Bytes enter on the s_axis channel, one per transaction, with s_axis_tuser high on
// the first byte of each message. Events leave on the m_axis channel; bytes that only
// update the running status or hold the first half of a pair give no event.
// The dialect register is written through cfg_valid/cfg_data; cfg_ready is always high,
// and writes are expected only while the parser is idle.
// A byte is registered on entry and decoded from the input register, and its event is
// registered into the output register once that register has space for it.
// Throughput is one byte per cycle: the input and output registers each free up in
// the cycle their contents move on, so s_axis_tready stays high while the receiver
// keeps up. When m_axis_tready is low the event is held; one more byte can be taken
// into the input register before s_axis_tready drops.
// Synchronous reset empties both registers, selects dialect 1 and restores the
// running status to note on, channel 0.
module midi_running_status_parser_unit
  import mrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] first_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] channel, [10:4] item_number, [24:11] item_value, [32:25] rejected_byte,
  // [39:33] zero
  output logic [39:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,  // [2:0] event_kind, [3] from_note_off
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

`include "midi_running_status_parser_unit_defines.svh"

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && space;

  mrsp_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .s_first (s_axis_tuser),
    .advance (advance),
    .valid   (in_valid),
    .item    (in_item)
  );

  mrsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .advance   (advance),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  mrsp_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && res_valid),
    .res     (res),
    .space   (space),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.rejected, out_res.value, out_res.number,
                         out_res.channel};
  assign m_axis_tuser = {out_res.from_note_off, out_res.kind};

  `MRSP_ASSERT_IMPL(a_note_off_flag, m_axis_tvalid && out_res.kind != KIND_NOTE,
      !out_res.from_note_off)
  `MRSP_ASSERT_IMPL(a_reject_byte, m_axis_tvalid && out_res.kind != KIND_REJECT,
      out_res.rejected == '0)
  `MRSP_ASSERT_IMPL(a_no_number,
      m_axis_tvalid && (out_res.kind == KIND_CHPR || out_res.kind == KIND_BEND ||
      out_res.kind == KIND_SYSEX || out_res.kind == KIND_REJECT),
      out_res.number == '0)

endmodule
